@@ hw/rtl/tga_pkg.sv @@
package tga_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int OUT_COORD_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_PIXELS = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_ROWS  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RLE_MODE     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_ORIGIN   = 3'd4;

  localparam logic [2:0] PIX_BYTES_24 = 3'd3;
  localparam logic [2:0] PIX_BYTES_32 = 3'd4;

  localparam logic [7:0] RUN_FLAG   = 8'h80;
  localparam logic [7:0] COUNT_MASK = 8'h7f;

  // one decoded pixel, or a bare end-of-stream marker when pix is low
  typedef struct packed {
    logic       pix;
    logic       pkt_end;
    logic       last;
    logic [7:0] count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } event_t;

  typedef struct packed {
    logic [OUT_COORD_BITS-1:0] row_index;
    logic [OUT_COORD_BITS-1:0] column_start;
    logic [7:0]                run_length;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic [7:0]                alpha;
    logic                      image_done;
    logic                      truncated;
  } result_t;

endpackage

@@ hw/rtl/tga_fifo.sv @@
module tga_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_BITS'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/tga_front.sv @@
module tga_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  input  logic           hold,
  input  logic [2:0]     pixel_bytes,
  input  logic           rle_mode,
  output logic           ev_push,
  output tga_pkg::event_t ev
);

  import tga_pkg::*;

  logic [7:0]  rem;
  logic [7:0]  rem_next;
  logic        rep;
  logic        rep_next;
  logic [1:0]  bpos;
  logic [1:0]  bpos_next;
  logic [23:0] buffer;
  logic        buf_we;
  logic        take;
  logic [1:0]  need;
  logic [7:0]  rem_eff;
  logic        rep_eff;

  assign take = push && !full && !hold;

  always_comb begin
    rem_next  = rem;
    rep_next  = rep;
    bpos_next = bpos;
    buf_we    = 1'b0;
    ev_push   = 1'b0;
    ev        = '0;
    need      = (pixel_bytes == PIX_BYTES_24) ? 2'd2 : 2'd3;
    rem_eff   = (rem == '0) ? 8'd1 : rem;
    rep_eff   = (rem == '0) ? 1'b0 : rep;
    if (take) begin
      ev.last = last_byte;
      if (rem == '0 && rle_mode) begin
        // packet header
        rep_next  = (data_byte & RUN_FLAG) != '0;
        rem_next  = (data_byte & COUNT_MASK) + 8'd1;
        bpos_next = 2'd0;
        ev_push   = last_byte;
      end else if (bpos < need) begin
        buf_we    = 1'b1;
        bpos_next = bpos + 2'd1;
        rem_next  = rem_eff;
        rep_next  = rep_eff;
        ev_push   = last_byte;
      end else begin
        bpos_next  = 2'd0;
        rep_next   = rep_eff;
        rem_next   = rep_eff ? 8'd0 : rem_eff - 8'd1;
        ev.pix     = 1'b1;
        ev.count   = rep_eff ? rem_eff : 8'd1;
        ev.pkt_end = (rem_next == '0);
        ev.blue    = buffer[7:0];
        ev.green   = buffer[15:8];
        ev.red     = (need == 2'd2) ? data_byte : buffer[23:16];
        ev.alpha   = (need == 2'd3) ? data_byte : 8'd0;
        ev_push    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      case (bpos)
        2'd0: begin
          buffer[7:0] <= data_byte;
        end
        2'd1: begin
          buffer[15:8] <= data_byte;
        end
        default: begin
          buffer[23:16] <= data_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      rep  <= 1'b0;
      bpos <= '0;
    end else begin
      rem  <= rem_next;
      rep  <= rep_next;
      bpos <= bpos_next;
    end
  end

endmodule

@@ hw/rtl/tga_back.sv @@
module tga_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ev_valid,
  input  tga_pkg::event_t       ev,
  input  logic [COORD_BITS-1:0] width_pixels,
  input  logic [COORD_BITS-1:0] height_rows,
  input  logic                  top_origin,
  input  logic                  pop,
  output logic                  ev_pop,
  output logic                  hold,
  output logic                  out_valid,
  output tga_pkg::result_t      res
);

  import tga_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB:0]   col;
  logic [CB-1:0] row;
  logic          complete;
  logic          failed;

  logic [CB:0]   wide;
  logic [CB:0]   cnt_w;
  logic [CB:0]   room;
  logic [CB:0]   len_w;
  logic [CB:0]   col_sum;
  logic [CB:0]   col_after;
  logic [CB-1:0] row_inc;
  logic [CB-1:0] row_after;
  logic [CB-1:0] row_sel;
  logic [CB-1:0] dest;
  logic [CB-1:0] col_clip;
  logic          in_row;
  logic          adv;
  logic          done;
  logic          trunc;
  logic          pix_out;
  logic          have;
  logic          work;
  result_t       res_next;

  assign hold   = complete || failed || (width_pixels == '0) || (height_rows == '0) ||
                  (row >= height_rows);
  assign ev_pop = ev_valid && (!out_valid || pop);
  assign work   = ev_pop && !hold;

  always_comb begin
    wide      = {1'b0, width_pixels};
    cnt_w     = (CB + 1)'(ev.count);
    in_row    = col < wide;
    room      = wide - col;
    len_w     = (room < cnt_w) ? room : cnt_w;
    col_sum   = col + cnt_w;
    row_inc   = row + 1'b1;
    adv       = ev.pix && ev.pkt_end && (col_sum >= wide);
    done      = adv && (row_inc >= height_rows);
    col_after = adv ? '0 : (ev.pix ? col_sum : col);
    row_after = adv ? row_inc : row;
    trunc     = ev.last && !done;
    pix_out   = ev.pix && in_row;
    have      = pix_out || done || trunc;
    row_sel   = (pix_out || done) ? row : row_after;
    dest      = top_origin ? row_sel : height_rows - 1'b1 - row_sel;
    col_clip  = (col_after > wide) ? width_pixels : col_after[CB-1:0];

    res_next              = '0;
    res_next.row_index    = OUT_COORD_BITS'(dest);
    res_next.image_done   = done;
    res_next.truncated    = trunc;
    if (pix_out) begin
      res_next.column_start = OUT_COORD_BITS'(col[CB-1:0]);
      res_next.run_length   = len_w[7:0];
      res_next.red          = ev.red;
      res_next.green        = ev.green;
      res_next.blue         = ev.blue;
      res_next.alpha        = ev.alpha;
    end else if (trunc) begin
      res_next.column_start = OUT_COORD_BITS'(col_clip);
    end
  end

  always_ff @(posedge clk) begin
    if (work && have) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      complete  <= 1'b0;
      failed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (work) begin
        col      <= col_after;
        row      <= row_after;
        complete <= done;
        failed   <= trunc;
      end
      if (ev_pop) begin
        out_valid <= work && have;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/tga_truecolor_rle_decoder.sv @@
// True-colour TGA pixel-data decoder, raw or RLE, one stream byte per item.
// Input channel: push/full with data_byte and last_byte; a byte is taken at
// an edge with push high and full low. Result channel: empty/pop; the oldest
// run (row, column, length, colour, image_done, truncated) is on the ports
// while empty is low and leaves at an edge with pop high.
// Configuration: cfg_write/cfg_index/cfg_data; write only while idle (the block does not enforce this).
// Throughput: one byte per cycle while full is low, including bytes that give runs.
// A byte that completes a pixel puts its event into the small event queue as it
// is taken; the run/row stage then loads the output register from the queue
// head, waiting behind older queued items or while the receiver stalls.
// The front keeps taking bytes while the receiver stalls until the event
// queue (QUEUE_DEPTH items) fills; full then stays high until pop frees it.
// Reset clears packet, column and row state, the queue and the output, and
// loads the registers with width 1, height 1, 4-byte pixels, raw, bottom-up.
// After the last pixel of the image, or a byte marked last, further bytes are
// taken and dropped until the next reset.
module tga_truecolor_rle_decoder #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tga_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tga_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  output logic                                empty,
  input  logic                                pop,
  output logic [tga_pkg::OUT_COORD_BITS-1:0]  row_index,
  output logic [tga_pkg::OUT_COORD_BITS-1:0]  column_start,
  output logic [7:0]                          run_length,
  output logic [7:0]                          red,
  output logic [7:0]                          green,
  output logic [7:0]                          blue,
  output logic [7:0]                          alpha,
  output logic                                image_done,
  output logic                                truncated
);

  import tga_pkg::*;

  logic [COORD_BITS-1:0] width_pixels;
  logic [COORD_BITS-1:0] height_rows;
  logic [2:0]            pixel_bytes;
  logic                  rle_mode;
  logic                  top_origin;

  logic    ev_push;
  logic    ev_pop;
  logic    ev_empty;
  logic    hold;
  logic    out_valid;
  event_t  ev_in;
  event_t  ev_out;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= COORD_BITS'(1);
      height_rows  <= COORD_BITS'(1);
      pixel_bytes  <= PIX_BYTES_32;
      rle_mode     <= 1'b0;
      top_origin   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH_PIXELS: begin
          width_pixels <= cfg_data[COORD_BITS-1:0];
        end
        REG_HEIGHT_ROWS: begin
          height_rows <= cfg_data[COORD_BITS-1:0];
        end
        REG_PIXEL_BYTES: begin
          pixel_bytes <= cfg_data[2:0];
        end
        REG_RLE_MODE: begin
          rle_mode <= cfg_data[0];
        end
        REG_TOP_ORIGIN: begin
          top_origin <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  tga_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .hold        (hold),
    .pixel_bytes (pixel_bytes),
    .rle_mode    (rle_mode),
    .ev_push     (ev_push),
    .ev          (ev_in)
  );

  tga_fifo #(
    .WIDTH ($bits(event_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .wdata (ev_in),
    .pop   (ev_pop),
    .rdata (ev_out),
    .full  (full),
    .empty (ev_empty)
  );

  tga_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (!ev_empty),
    .ev           (ev_out),
    .width_pixels (width_pixels),
    .height_rows  (height_rows),
    .top_origin   (top_origin),
    .pop          (pop),
    .ev_pop       (ev_pop),
    .hold         (hold),
    .out_valid    (out_valid),
    .res          (res)
  );

  assign empty        = !out_valid;
  assign row_index    = res.row_index;
  assign column_start = res.column_start;
  assign run_length   = res.run_length;
  assign red          = res.red;
  assign green        = res.green;
  assign blue         = res.blue;
  assign alpha        = res.alpha;
  assign image_done   = res.image_done;
  assign truncated    = res.truncated;

endmodule
